// ----- sv/vml_pkg.sv -----
// Shared types and constants for the vector magnitude limiter.
`timescale 1ns / 1ps

package vml_pkg;

	// Component width, used by the payload structs below
	localparam int COMP_W  = 16;
	// Limit register width
	localparam int LIM_W   = 15;
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(32767);

	// Sum of squares, square-root partial remainder, scaled product
	localparam int SUM_W   = 2 * COMP_W;
	localparam int REM_W   = COMP_W + 1;
	localparam int PROD_W  = COMP_W + LIM_W;
	localparam int LIM_PAD = COMP_W - LIM_W;

	// Input request
	typedef struct packed {
		logic signed [COMP_W-1:0] x_in;
		logic signed [COMP_W-1:0] y_in;
	} in_item_t;

	// Result request
	typedef struct packed {
		logic signed [COMP_W-1:0] x_out;
		logic signed [COMP_W-1:0] y_out;
		logic                     was_limited;
	} out_item_t;

	// Sign and magnitude of both components, carried down the pipe
	typedef struct packed {
		logic              x_neg;
		logic              y_neg;
		logic [COMP_W-1:0] x_mag;
		logic [COMP_W-1:0] y_mag;
	} side_t;

	// Square-root cell state: radicand bits still to consume, remainder, partial root
	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [COMP_W-1:0] root;
		side_t             side;
	} sqrt_t;

	// Divider cell state: shared divisor, per lane remainder and dividend/quotient shifter
	typedef struct packed {
		logic              x_neg;
		logic              y_neg;
		logic              limited;
		logic [COMP_W-1:0] divisor;
		logic [COMP_W-1:0] x_rem;
		logic [COMP_W-1:0] x_lo;
		logic [COMP_W-1:0] y_rem;
		logic [COMP_W-1:0] y_lo;
	} div_t;

endpackage

// ----- sv/vml_sqrt_cell.sv -----
// One digit cell of the pipelined square root: two radicand bits in, one root bit out.
`timescale 1ns / 1ps

module vml_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  vml_pkg::sqrt_t d,
	output vml_pkg::sqrt_t q
);
	import vml_pkg::*;

	logic [REM_W+1:0] t;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;
	sqrt_t            nxt;

	// Bring down the next bit pair and try 4*root + 1
	always_comb begin
		t        = {d.rem, d.rad[SUM_W-1 -: 2]};
		trial    = {{(REM_W-COMP_W){1'b0}}, d.root, 2'b01};
		diff     = t - trial;
		ge       = (t >= trial);
		nxt      = d;
		nxt.rad  = {d.rad[SUM_W-3:0], 2'b00};
		nxt.rem  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
		nxt.root = {d.root[COMP_W-2:0], ge};
	end

	// Cell register
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ----- sv/vml_div_cell.sv -----
// One restoring-division cell: a quotient bit for each of the two component lanes.
`timescale 1ns / 1ps

module vml_div_cell (
	input  logic          clk,
	input  logic          en,
	input  vml_pkg::div_t d,
	output vml_pkg::div_t q
);
	import vml_pkg::*;

	logic [COMP_W:0] dv;
	logic [COMP_W:0] xt;
	logic [COMP_W:0] yt;
	logic [COMP_W:0] xdiff;
	logic [COMP_W:0] ydiff;
	logic            xge;
	logic            yge;
	div_t            nxt;

	// Shift in the next dividend bit, subtract the divisor where it fits
	always_comb begin
		dv       = {1'b0, d.divisor};
		xt       = {d.x_rem, d.x_lo[COMP_W-1]};
		yt       = {d.y_rem, d.y_lo[COMP_W-1]};
		xdiff    = xt - dv;
		ydiff    = yt - dv;
		xge      = (xt >= dv);
		yge      = (yt >= dv);
		nxt      = d;
		nxt.x_rem = xge ? xdiff[COMP_W-1:0] : xt[COMP_W-1:0];
		nxt.y_rem = yge ? ydiff[COMP_W-1:0] : yt[COMP_W-1:0];
		nxt.x_lo  = {d.x_lo[COMP_W-2:0], xge};
		nxt.y_lo  = {d.y_lo[COMP_W-2:0], yge};
	end

	// Cell register
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ----- sv/vector_magnitude_limiter_core.sv -----
// Top level of the vector magnitude limiter: front end, cell chains, output skid buffer.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | in        | in_valid / in_ready  | in_data  (x_in, y_in)
//  out     | out       | out_valid/ out_ready | out_data (x_out, y_out, was_limited)
//  cfg     | in        | cfg_valid/ cfg_ready | cfg_data (magnitude_limit)
//
// One request per cycle while the skid register is free; a request passes through
// three front stages (magnitude, square, sum), 16 square-root cells, compare and
// multiply stages, 16 divider cells, then the output register.
// Reset empties the pipe and sets the limit to 32767; cfg_ready is always high.
// A stalled output catches one more result in a skid register; in_ready then drops
// and the whole pipe holds until that result moves up.

module vector_magnitude_limiter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vml_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vml_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vml_pkg::LIM_W-1:0]       cfg_data
);
	import vml_pkg::*;

	localparam int SQ_N  = COMP_W;
	localparam int DV_N  = COMP_W;
	localparam int ST_S5 = 4 + SQ_N;
	localparam int NST   = 5 + SQ_N + DV_N;

	logic [LIM_W-1:0]  limit_q;
	logic [NST-1:0]    vld_q;
	logic              en;
	logic              push;
	logic              pop;

	side_t             side_d;
	side_t             side_s1;
	side_t             side_s2;
	logic [SUM_W-1:0]  xsq_d;
	logic [SUM_W-1:0]  ysq_d;
	logic [SUM_W-1:0]  xsq_s2;
	logic [SUM_W-1:0]  ysq_s2;
	sqrt_t             sq_s3;
	sqrt_t             sq_chain [SQ_N+1];

	logic [COMP_W-1:0] norm;
	logic              lim_d;
	logic              lim_s4;
	logic [LIM_W-1:0]  fac_s4;
	logic [COMP_W-1:0] dvs_s4;
	side_t             side_s4;
	logic [PROD_W-1:0] xprod;
	logic [PROD_W-1:0] yprod;
	div_t              dv_s5;
	div_t              dv_chain [DV_N+1];

	logic [COMP_W-1:0] xq;
	logic [COMP_W-1:0] yq;
	out_item_t         res_d;
	out_item_t         out_q;
	out_item_t         skid_q;
	logic              out_vld_q;
	logic              skid_vld_q;

	// Pipe moves whenever the skid register is free
	assign en       = !skid_vld_q;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// Sign and magnitude split
	always_comb begin
		side_d.x_neg = in_data.x_in[COMP_W-1];
		side_d.y_neg = in_data.y_in[COMP_W-1];
		side_d.x_mag = side_d.x_neg ? (~in_data.x_in + 1'b1) : in_data.x_in;
		side_d.y_mag = side_d.y_neg ? (~in_data.y_in + 1'b1) : in_data.y_in;
	end

	// Squares
	always_comb begin
		xsq_d = side_s1.x_mag * side_s1.x_mag;
		ysq_d = side_s1.y_mag * side_s1.y_mag;
	end

	// Front stages
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1    <= side_d;
			side_s2    <= side_s1;
			xsq_s2     <= xsq_d;
			ysq_s2     <= ysq_d;
			sq_s3.rad  <= xsq_s2 + ysq_s2;
			sq_s3.rem  <= '0;
			sq_s3.root <= '0;
			sq_s3.side <= side_s2;
		end
	end

	// Square-root chain
	assign sq_chain[0] = sq_s3;
	for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
		vml_sqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_chain[i]),
			.q   (sq_chain[i+1])
		);
	end

	// Compare against the limit; pass-through divides by one
	assign norm  = sq_chain[SQ_N].root;
	assign lim_d = (norm > {{LIM_PAD{1'b0}}, limit_q});

	always_ff @(posedge clk) begin
		if (en) begin
			lim_s4  <= lim_d;
			fac_s4  <= lim_d ? limit_q : LIM_W'(1);
			dvs_s4  <= lim_d ? norm : COMP_W'(1);
			side_s4 <= sq_chain[SQ_N].side;
		end
	end

	// Scale magnitudes by the limit, or by one on pass-through
	always_comb begin
		xprod = side_s4.x_mag * fac_s4;
		yprod = side_s4.y_mag * fac_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s5.x_neg   <= side_s4.x_neg;
			dv_s5.y_neg   <= side_s4.y_neg;
			dv_s5.limited <= lim_s4;
			dv_s5.divisor <= dvs_s4;
			dv_s5.x_rem   <= {{LIM_PAD{1'b0}}, xprod[PROD_W-1:COMP_W]};
			dv_s5.x_lo    <= xprod[COMP_W-1:0];
			dv_s5.y_rem   <= {{LIM_PAD{1'b0}}, yprod[PROD_W-1:COMP_W]};
			dv_s5.y_lo    <= yprod[COMP_W-1:0];
		end
	end

	// Divider chain
	assign dv_chain[0] = dv_s5;
	for (genvar i = 0; i < DV_N; i++) begin : g_div
		vml_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (dv_chain[i]),
			.q   (dv_chain[i+1])
		);
	end

	// Restore signs
	always_comb begin
		xq                = dv_chain[DV_N].x_lo;
		yq                = dv_chain[DV_N].y_lo;
		res_d.x_out       = dv_chain[DV_N].x_neg ? (~xq + 1'b1) : xq;
		res_d.y_out       = dv_chain[DV_N].y_neg ? (~yq + 1'b1) : yq;
		res_d.was_limited = dv_chain[DV_N].limited;
	end

	assign push = vld_q[NST-1] && en;
	assign pop  = out_vld_q && out_ready;

	// Output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !out_ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !out_ready) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// Skid only ever holds a result behind a waiting one
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while output register empty");

	// Skid fills only on a stalled output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid register filled without an output stall");

	// Divider never sees a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_S5] |-> (dv_s5.divisor != '0))
		else $error("zero divisor entered the divider chain");

endmodule

// ----- tb/tb_vector_magnitude_limiter_core.sv -----
// Self-checking testbench for the vector magnitude limiter core.
`timescale 1ns / 1ps

module tb_vector_magnitude_limiter_core;
	import vml_pkg::*;

	localparam int DRAIN_CYCLES = 45;      // pipe latency plus margin
	localparam int HOLD_CYCLES  = 300;     // long output stall, well past pipe depth
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 105;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIM_W-1:0]   cfg_data;

	// Stimulus and expected results
	in_item_t           vector_q[$];
	out_item_t          clamped_q[$];
	out_item_t          want;
	logic [LIM_W-1:0]   limit_now;

	// Handshake notes from the monitor to the driver and receiver
	bit                 vec_taken;
	bit                 res_taken;
	bit                 send_idle;
	bit                 recv_idle;
	int                 send_wait;
	int                 recv_wait;
	int                 hold_left;

	// Counters
	int                 cycle_count;
	int                 cfg_writes;
	int                 vecs_sent;
	int                 results_seen;
	int                 clamped_seen;
	int                 in_stalls;
	int                 errors;

	vector_magnitude_limiter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Expected output: scale both components by limit/norm when the floored norm is over the limit
	function automatic out_item_t clamp_vector(in_item_t v, logic [LIM_W-1:0] lim);
		longint    sx;
		longint    sy;
		longint    ax;
		longint    ay;
		longint    sq;
		longint    root;
		longint    trial;
		out_item_t r;
		sx = v.x_in;
		sy = v.y_in;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		sq = ax * ax + ay * ay;
		// bitwise floor square root, root fits in 17 bits
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= sq)
				root = trial;
		end
		r.was_limited = (root > longint'(lim));
		if (r.was_limited) begin
			ax = (ax * longint'(lim)) / root;
			ay = (ay * longint'(lim)) / root;
		end
		r.x_out = COMP_W'((sx < 0) ? -ax : ax);
		r.y_out = COMP_W'((sy < 0) ? -ay : ay);
		return r;
	endfunction

	// Monitor: take requests, predict, and check results at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				limit_now = cfg_data;
				cfg_writes++;
			end
			if (in_valid && !in_ready)
				in_stalls++;
			if (in_valid && in_ready) begin
				clamped_q.push_back(clamp_vector(in_data, limit_now));
				vec_taken = 1'b1;
				vecs_sent++;
			end
			if (out_valid && out_ready) begin
				res_taken = 1'b1;
				results_seen++;
				if (clamped_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result x=%0d y=%0d limited=%0b",
							out_data.x_out, out_data.y_out, out_data.was_limited);
				end else begin
					want = clamped_q.pop_front();
					if (want.was_limited)
						clamped_seen++;
					if (out_data.x_out !== want.x_out || out_data.y_out !== want.y_out ||
							out_data.was_limited !== want.was_limited) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch at result %0d: expected x=%0d y=%0d ",
								"limited=%0b, got x=%0d y=%0d limited=%0b"},
								results_seen, want.x_out, want.y_out, want.was_limited,
								out_data.x_out, out_data.y_out, out_data.was_limited);
					end
				end
			end
		end
	end

	// Driver: present queued vectors, random gap between requests when send_idle is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (vec_taken || !in_valid) begin
				vec_taken = 1'b0;
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (vector_q.size() > 0) begin
					in_data  <= vector_q.pop_front();
					in_valid <= 1'b1;
					send_wait = send_idle ? $urandom_range(0, 13) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall after each result when recv_idle is set, plus the long hold when asked
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				res_taken = 1'b0;
				recv_wait = recv_idle ? $urandom_range(0, 13) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results pending", cycle_count, clamped_q.size());
		$display("tb_vector_magnitude_limiter_core NOT OK");
		$finish;
	end

	task automatic queue_vector(int x, int y);
		in_item_t v;
		v.x_in = COMP_W'(x);
		v.y_in = COMP_W'(y);
		vector_q.push_back(v);
	endtask

	// Mix of full-range vectors, vectors near the current limit and corner values
	task automatic queue_random(int n);
		in_item_t v;
		int       pick;
		int       span;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			span = (int'(limit_now) + 2 > 32767) ? 32767 : int'(limit_now) + 2;
			if (pick < 5) begin
				v = in_item_t'($urandom);
			end else if (pick < 8) begin
				v.x_in = COMP_W'($urandom_range(0, 2 * span) - span);
				v.y_in = COMP_W'($urandom_range(0, 2 * span) - span);
			end else begin
				// around zero, the most negative and the most positive values
				v.x_in = ($urandom_range(0, 1) ? 16'h8000 : 16'h0000) ^
					($urandom_range(0, 1) ? 16'h7FFF : 16'h0000) ^ 16'($urandom_range(0, 1));
				v.y_in = ($urandom_range(0, 1) ? 16'h8000 : 16'h0000) ^
					($urandom_range(0, 1) ? 16'h7FFF : 16'h0000) ^ 16'($urandom_range(0, 1));
			end
			vector_q.push_back(v);
		end
	endtask

	// Wait until every request is taken and every result checked, then let the pipe settle
	task automatic wait_idle();
		do @(negedge clk);
		while (vector_q.size() != 0 || clamped_q.size() != 0 || in_valid);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [LIM_W-1:0] v);
		int seen;
		seen = cfg_writes;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk);
		while (cfg_writes == seen);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		limit_now = LIM_RESET;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset limit: extremes, most negative components, exact integer norms
		queue_vector(0, 0);
		queue_vector(32767, 32767);
		queue_vector(-32768, -32768);
		queue_vector(-32768, 0);
		queue_vector(0, -32768);
		queue_vector(32767, -32768);
		queue_vector(1, 0);
		queue_vector(-1, -1);
		queue_vector(3, 4);
		queue_vector(-23170, 23170);
		wait_idle();

		// Zero limit: every nonzero vector collapses to the origin
		write_limit(LIM_W'(0));
		queue_vector(0, 0);
		queue_vector(1, 0);
		queue_vector(-32768, 5);
		wait_idle();

		// Small limit: on the boundary, just over it before flooring, negative signs
		write_limit(LIM_W'(5));
		queue_vector(3, 4);
		queue_vector(3, 5);
		queue_vector(-4, 3);
		queue_vector(-32768, -32768);
		queue_vector(32767, 1);
		wait_idle();

		// Random phases over several limits and idling patterns
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_limit(LIM_W'(32767));
				1: write_limit(LIM_W'(0));
				2: write_limit(LIM_W'(1));
				3: write_limit(LIM_W'(15'h5555));
				4: write_limit(LIM_W'(15'h2AAA));
				default: write_limit(LIM_W'($urandom_range(0, 32767)));
			endcase
			send_idle = (p != 2 && p != 4);
			recv_idle = (p != 3 && p != 4);
			if (p == 2) begin
				// output held off while the sender streams, so the pipe fills and in_ready drops
				@(posedge clk);
				hold_left = HOLD_CYCLES;
			end
			queue_random(PHASE_ITEMS);
			wait_idle();
		end

		if (clamped_q.size() != 0)
			errors++;
		$display("covered %0d vectors over %0d limit writes: %0d clamped, %0d passed through",
			vecs_sent, cfg_writes, clamped_seen, results_seen - clamped_seen);
		$display("input stalled for %0d cycles, %0d mismatches", in_stalls, errors);
		if (errors == 0)
			$display("tb_vector_magnitude_limiter_core OK");
		else
			$display("tb_vector_magnitude_limiter_core NOT OK");
		$finish;
	end

endmodule
